// File: hw/rtl/wsd_pkg.sv
package wsd_pkg;

  // parser phases
  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_MASK = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_SHORT_HDR   = 3'd1;
  localparam logic [2:0] ERR_SHORT_LEN   = 3'd2;
  localparam logic [2:0] ERR_SHORT_MASK  = 3'd3;
  localparam logic [2:0] ERR_SHORT_PAYLD = 3'd4;

  // 7-bit length escapes
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_BYTES  = 4'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       frame_last;
    logic [2:0] error_code;
  } wsd_result_t;

endpackage

// File: hw/rtl/wsd_parser.sv
module wsd_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           rx_byte,
  input  logic                 chunk_end,
  output logic                 res_valid,
  output wsd_pkg::wsd_result_t res
);

  logic [2:0]  phase, phase_next;
  logic        final_flag, final_flag_next;
  logic        mask_present, mask_present_next;
  logic [3:0]  ext_bytes_left, ext_bytes_left_next;
  logic [63:0] payload_left, payload_left_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  key_index, key_index_next;

  logic        len_done;   // length known, go to mask or payload
  logic        pay_start;  // mask known or absent, start payload
  logic        len_zero;
  logic        last;
  logic [7:0]  kb;
  logic [2:0]  code;

  always_comb begin
    phase_next          = phase;
    final_flag_next     = final_flag;
    mask_present_next   = mask_present;
    ext_bytes_left_next = ext_bytes_left;
    payload_left_next   = payload_left;
    mask_key_next       = mask_key;
    key_index_next      = key_index;
    len_done            = 1'b0;
    pay_start           = 1'b0;
    len_zero            = 1'b0;
    last                = 1'b0;
    kb                  = 8'd0;
    code                = wsd_pkg::ERR_NONE;
    res_valid           = 1'b0;
    res                 = '0;

    unique case (phase)
      wsd_pkg::PH_HDR0: begin
        final_flag_next = rx_byte[7];
        phase_next      = wsd_pkg::PH_HDR1;
      end
      wsd_pkg::PH_HDR1: begin
        mask_present_next = rx_byte[7];
        payload_left_next = '0;
        if (rx_byte[6:0] == wsd_pkg::LEN7_EXT16) begin
          ext_bytes_left_next = wsd_pkg::EXT16_BYTES;
          phase_next          = wsd_pkg::PH_EXT;
        end else if (rx_byte[6:0] == wsd_pkg::LEN7_EXT64) begin
          ext_bytes_left_next = wsd_pkg::EXT64_BYTES;
          phase_next          = wsd_pkg::PH_EXT;
        end else begin
          payload_left_next = {57'd0, rx_byte[6:0]};
          len_done          = 1'b1;
          len_zero          = (rx_byte[6:0] == 7'd0);
        end
      end
      wsd_pkg::PH_EXT: begin
        payload_left_next   = {payload_left[55:0], rx_byte};
        ext_bytes_left_next = ext_bytes_left - 4'd1;
        if (ext_bytes_left_next == 4'd0) begin
          len_done = 1'b1;
          len_zero = (payload_left_next == 64'd0);
        end
      end
      wsd_pkg::PH_MASK: begin
        mask_key_next       = {mask_key[23:0], rx_byte};
        ext_bytes_left_next = ext_bytes_left - 4'd1;
        if (ext_bytes_left_next == 4'd0) begin
          pay_start = 1'b1;
          len_zero  = (payload_left == 64'd0);
        end
      end
      wsd_pkg::PH_DATA: begin
        if (mask_present) begin
          unique case (key_index)
            2'd0:    kb = mask_key[31:24];
            2'd1:    kb = mask_key[23:16];
            2'd2:    kb = mask_key[15:8];
            default: kb = mask_key[7:0];
          endcase
        end
        key_index_next    = key_index + 2'd1;
        payload_left_next = payload_left - 64'd1;
        last              = (payload_left == 64'd1);
        if (last) begin
          phase_next = wsd_pkg::PH_SKIP;
        end
        if (final_flag && !(chunk_end && !last)) begin
          res_valid        = 1'b1;
          res.kind         = wsd_pkg::KIND_PAYLOAD;
          res.payload_byte = rx_byte ^ kb;
          res.frame_last   = last;
        end
      end
      default: begin
        // discard until the chunk ends
      end
    endcase

    if (len_done) begin
      mask_key_next = '0;
      if (mask_present_next) begin
        ext_bytes_left_next = wsd_pkg::MASK_BYTES;
        phase_next          = wsd_pkg::PH_MASK;
      end else begin
        pay_start = 1'b1;
      end
    end

    if (pay_start) begin
      key_index_next = '0;
      if (len_zero) begin
        phase_next = wsd_pkg::PH_SKIP;
        if (final_flag_next) begin
          res_valid = 1'b1;
          res.kind  = wsd_pkg::KIND_EMPTY;
        end
      end else begin
        phase_next = wsd_pkg::PH_DATA;
      end
    end

    if (chunk_end) begin
      priority case (phase_next)
        wsd_pkg::PH_HDR1: code = wsd_pkg::ERR_SHORT_HDR;
        wsd_pkg::PH_EXT:  code = wsd_pkg::ERR_SHORT_LEN;
        wsd_pkg::PH_MASK: code = wsd_pkg::ERR_SHORT_MASK;
        wsd_pkg::PH_DATA: code = wsd_pkg::ERR_SHORT_PAYLD;
        default:          code = wsd_pkg::ERR_NONE;
      endcase
      if (code != wsd_pkg::ERR_NONE) begin
        res_valid      = 1'b1;
        res            = '0;
        res.kind       = wsd_pkg::KIND_ERROR;
        res.error_code = code;
      end
      phase_next = wsd_pkg::PH_HDR0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= wsd_pkg::PH_HDR0;
      final_flag     <= 1'b0;
      mask_present   <= 1'b0;
      ext_bytes_left <= '0;
      payload_left   <= '0;
      mask_key       <= '0;
      key_index      <= '0;
    end else if (take) begin
      phase          <= phase_next;
      final_flag     <= final_flag_next;
      mask_present   <= mask_present_next;
      ext_bytes_left <= ext_bytes_left_next;
      payload_left   <= payload_left_next;
      mask_key       <= mask_key_next;
      key_index      <= key_index_next;
    end
  end

  // a chunk end always restarts the header
  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    take && chunk_end |=> phase == wsd_pkg::PH_HDR0)
    else $error("parser did not return to first header byte after chunk end");

  // errors only come from a chunk end
  a_err_on_end: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && res.kind == wsd_pkg::KIND_ERROR |-> chunk_end)
    else $error("error result without chunk end");

  // last payload byte leaves the payload phase
  a_last_leaves: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && res.kind == wsd_pkg::KIND_PAYLOAD && res.frame_last
    |=> phase != wsd_pkg::PH_DATA)
    else $error("still in payload after last byte");

endmodule

// File: hw/rtl/wsd_out_reg.sv
module wsd_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  wsd_pkg::wsd_result_t res,
  output logic                 space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wsd_pkg::wsd_result_t held
);

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

// File: hw/rtl/websocket_frame_deframer.sv
// WebSocket frame deframer, receive side.
// Input channel: in_valid/in_ready with rx_byte and chunk_end; chunk_end
// flags the last byte of a received chunk, and the next chunk starts a
// fresh frame header.
// Output channel: out_valid/out_ready with kind, payload_byte, frame_last
// and error_code. Each input item gives zero or one result item: an
// unmasked payload byte of a final frame, an empty-frame marker, or an
// error when a chunk stops short of a full header or payload.
// Latency: a result is registered and appears on the output in the cycle
// after its byte is accepted. Throughput: one byte per cycle while the
// output register is empty or out_ready is high, set by the single output register.
// Stall: while a result is held and out_ready is low, in_ready is low;
// when out_ready is high a new byte is taken in the same cycle the held
// result leaves.
// Reset (synchronous, rst high) returns the parser to the first header
// byte and empties the output register.
module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       chunk_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] payload_byte,
  output logic       frame_last,
  output logic [2:0] error_code
);

  logic                 take;
  logic                 res_valid;
  wsd_pkg::wsd_result_t res;
  wsd_pkg::wsd_result_t held;

  // parser steps only on an accepted item
  assign take = in_valid && in_ready;

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .chunk_end (chunk_end),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register parts the two sides
  wsd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_valid),
    .res       (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign kind         = held.kind;
  assign payload_byte = held.payload_byte;
  assign frame_last   = held.frame_last;
  assign error_code   = held.error_code;

  // an error result always carries a code, other kinds never do
  a_code_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == wsd_pkg::KIND_ERROR) == (error_code != wsd_pkg::ERR_NONE)))
    else $error("error code does not match kind");

  // only payload results carry data
  a_clean_nonpayload: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != wsd_pkg::KIND_PAYLOAD |-> payload_byte == 8'd0 && !frame_last)
    else $error("non-payload result carries data");

  // kind stays within its codes
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind == wsd_pkg::KIND_PAYLOAD || kind == wsd_pkg::KIND_EMPTY
                  || kind == wsd_pkg::KIND_ERROR)
    else $error("bad result kind");

endmodule
